// ===== src/crcff_pkg.sv =====
// ----------------------------------------------------------------------------
// crcff_pkg: shared types and functions for the CRC-checked frame filter
// Frame geometry, status codes, CRC-16 byte update and stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package crcff_pkg;

  localparam int FRAME_LEN  = 11;
  localparam int HASHED_LEN = 9;
  localparam int STORED_LEN = FRAME_LEN - 1;

  localparam logic [3:0] POS_LAST = 4'(FRAME_LEN - 1);
  localparam logic [3:0] POS_SAT  = 4'(FRAME_LEN + 1);
  localparam logic [3:0] POS_HASH = 4'(HASHED_LEN);

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 176;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_CRC    = 2'd1,
    STATUS_PLAUS  = 2'd2,
    STATUS_XFER   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
    logic       transfer_error;
  } in_item_t;

  typedef struct packed {
    logic [31:0] general_fail_count;
    logic [31:0] hash_fail_count;
    logic [31:0] read_count;
    logic        shutdown_request;
    logic [7:0]  good_payload_high;
    logic [63:0] good_payload_low;
    status_t     status;
  } result_t;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/crcff_ingress.sv =====
// ----------------------------------------------------------------------------
// crcff_ingress: input register
// Holds one received byte transaction until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crcff_ingress
  import crcff_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/crcff_core.sv =====
// ----------------------------------------------------------------------------
// crcff_core: frame assembly, CRC check, plausibility filter and counters
// Updates frame state per byte and forms the result at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module crcff_core
  import crcff_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire in_item_t item,
  output logic          frame_end,
  output result_t       result
);

  logic [3:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  frame_bytes [STORED_LEN];
  logic [7:0]  last_good_payload [HASHED_LEN];
  logic [7:0]  ref_first_byte;
  logic [6:0]  ref_second_byte;
  logic [1:0]  mismatch_run;
  logic        shutdown_latched;
  logic [31:0] frames_read;
  logic [31:0] hash_fails;
  logic [31:0] general_fails;

  logic [3:0]  byte_position_next;
  logic [15:0] crc_inv;
  logic        len_ok;
  logic        crc_ok;
  logic        mismatch;
  status_t     status;
  logic [1:0]  mismatch_run_next;
  logic        refs_load;
  logic        keep;
  logic [7:0]  payload_next [HASHED_LEN];
  logic        pulse;
  logic [31:0] frames_read_next;
  logic [31:0] hash_fails_next;
  logic [31:0] general_fails_next;

  assign frame_end = item.transfer_error || item.end_of_frame;
  assign byte_position_next = (byte_position < POS_SAT) ? byte_position + 4'd1 : byte_position;

  assign crc_inv  = ~running_crc;
  assign len_ok   = !item.transfer_error && (byte_position == POS_LAST);
  assign crc_ok   = {crc_inv[7:0], crc_inv[15:8]} == {frame_bytes[STORED_LEN-1], item.rx_byte};
  assign mismatch = (frame_bytes[0] != ref_first_byte) &&
                    (frame_bytes[1][6:0] != ref_second_byte);

  always_comb begin
    status            = STATUS_OK;
    mismatch_run_next = mismatch_run;
    refs_load         = 1'b0;
    if (!len_ok) begin
      status = STATUS_XFER;
    end else if (!crc_ok) begin
      status = STATUS_CRC;
    end else if (mismatch) begin
      if (mismatch_run != 2'd0) begin
        status            = STATUS_PLAUS;
        mismatch_run_next = 2'd2;
      end else begin
        mismatch_run_next = 2'd1;
      end
    end else begin
      refs_load         = 1'b1;
      mismatch_run_next = 2'd0;
    end
  end

  assign keep = (status == STATUS_OK);

  always_comb begin
    for (int i = 0; i < HASHED_LEN; i++) begin
      payload_next[i] = keep ? frame_bytes[i] : last_good_payload[i];
    end
  end

  assign pulse              = !shutdown_latched && payload_next[1][7];
  assign frames_read_next   = frames_read + 32'd1;
  assign hash_fails_next    = (status == STATUS_CRC || status == STATUS_PLAUS) ?
                              hash_fails + 32'd1 : hash_fails;
  assign general_fails_next = (status == STATUS_XFER) ? general_fails + 32'd1 : general_fails;

  always_comb begin
    result.status             = status;
    result.good_payload_high  = payload_next[HASHED_LEN-1];
    result.shutdown_request   = pulse;
    result.read_count         = frames_read_next;
    result.hash_fail_count    = hash_fails_next;
    result.general_fail_count = general_fails_next;
    for (int i = 0; i < 8; i++) begin
      result.good_payload_low[8*i +: 8] = payload_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      ref_first_byte   <= '0;
      ref_second_byte  <= '0;
      mismatch_run     <= '0;
      shutdown_latched <= 1'b0;
      frames_read      <= '0;
      hash_fails       <= '0;
      general_fails    <= '0;
      for (int i = 0; i < HASHED_LEN; i++) begin
        last_good_payload[i] <= '0;
      end
    end else if (step) begin
      if (frame_end) begin
        byte_position    <= '0;
        running_crc      <= CRC_INIT;
        frames_read      <= frames_read_next;
        hash_fails       <= hash_fails_next;
        general_fails    <= general_fails_next;
        shutdown_latched <= shutdown_latched || pulse;
        if (len_ok && crc_ok) begin
          mismatch_run <= mismatch_run_next;
        end
        if (len_ok && crc_ok && refs_load) begin
          ref_first_byte  <= frame_bytes[0];
          ref_second_byte <= frame_bytes[1][6:0];
        end
        for (int i = 0; i < HASHED_LEN; i++) begin
          last_good_payload[i] <= payload_next[i];
        end
      end else begin
        byte_position <= byte_position_next;
        if (byte_position < POS_HASH) begin
          running_crc <= crc_byte(running_crc, item.rx_byte);
        end
      end
    end
  end

  // Frame byte store, written at the current position; byte 10 is used live
  always_ff @(posedge clk) begin
    if (step && !item.transfer_error) begin
      for (int i = 0; i < STORED_LEN; i++) begin
        if (byte_position == 4'(i)) begin
          frame_bytes[i] <= item.rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/crc_checked_frame_filter.sv =====
// Path: a frame's last byte transaction passes the input register, then the
// output register, which holds the result until it is taken.
// Throughput: one byte per cycle while the result side accepts; while a result
// waits unaccepted in the output register, no byte moves through the core.
// Reset: synchronous, active high; clears counters, references, kept payload
// and frame position, and empties both registers.
// ----------------------------------------------------------------------------
// crc_checked_frame_filter: CRC-16 checked 11-byte frame filter
// Input register, per-byte core and output register on stream channels.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_filter
  import crcff_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // rx_byte[7:0]
  input  wire logic                   s_tlast,  // end_of_frame
  input  wire logic                   s_tuser,  // transfer_error
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status[1:0], good_payload_low[65:2], good_payload_high[73:66],
  // shutdown_request[74], read_count[106:75], hash_fail_count[138:107],
  // general_fail_count[170:139], zero[175:171]
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_free;
  logic     step;
  logic     frame_end;
  result_t  result;
  result_t  out_reg;

  assign in_item.rx_byte        = s_tdata;
  assign in_item.end_of_frame   = s_tlast;
  assign in_item.transfer_error = s_tuser;

  assign out_free = !m_tvalid || m_tready;
  assign step     = item_valid && out_free;

  crcff_ingress u_ingress (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  crcff_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .frame_end (frame_end),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frame_end) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_reg};

endmodule

`default_nettype wire

// ===== src/crcff_checker.sv =====
// ----------------------------------------------------------------------------
// crcff_checker: port-level checks for the frame filter
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcff_checker
  import crcff_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_shutdown_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[74] |-> m_tdata[17])
    else $error("shutdown without kept byte1 bit7");

  a_shutdown_once: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[74] |=> !(m_tvalid && m_tdata[74]))
    else $error("shutdown raised twice");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[175:171] == 5'd0)
    else $error("nonzero pad bits");

endmodule

bind crc_checked_frame_filter crcff_checker u_crcff_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/crc_checked_frame_filter_tb.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_filter_tb: self-checking bench for the CRC frame filter
// Streams frame bytes in and predicts one verdict per finished frame: CRC-16
// check, plausibility filter, kept payload, shutdown pulse and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_filter_tb;
  import crcff_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // rx_byte[7:0]
  logic                   s_tlast;   // end_of_frame
  logic                   s_tuser;   // transfer_error
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // status, payload low/high, shutdown, counters

  crc_checked_frame_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic [3:0]  pos_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  rx_frame [FRAME_LEN];
  logic [7:0]  kept_payload [HASHED_LEN];
  logic [7:0]  anchor_b0;
  logic [6:0]  anchor_b1;
  logic [1:0]  reject_streak;
  logic        shutdown_done;
  logic [31:0] n_frames;
  logic [31:0] n_hash_fail;
  logic [31:0] n_gen_fail;

  result_t pending_verdicts [$];

  logic [7:0] tx_frame [16];
  int  bytes_sent;
  int  mismatches;
  int  idle_cycles;
  int  stall_left;
  bit  no_gaps;
  bit  hold_req;

  function automatic logic [15:0] crc16_x25_step(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic status_t judge_frame();
    logic [15:0] inv;
    logic [6:0]  b1;
    inv = ~crc_acc;
    b1  = rx_frame[1][6:0];
    if ({inv[7:0], inv[15:8]} != {rx_frame[9], rx_frame[10]}) begin
      return STATUS_CRC;
    end
    if (rx_frame[0] != anchor_b0 && b1 != anchor_b1) begin
      if (reject_streak > 1) begin
        return STATUS_PLAUS;
      end
      reject_streak = reject_streak + 1'b1;
      if (reject_streak > 1) begin
        return STATUS_PLAUS;
      end
    end else begin
      anchor_b0     = rx_frame[0];
      anchor_b1     = b1;
      reject_streak = '0;
    end
    for (int k = 0; k < HASHED_LEN; k++) begin
      kept_payload[k] = rx_frame[k];
    end
    return STATUS_OK;
  endfunction

  function automatic void absorb_byte(logic [7:0] b, logic eof, logic err);
    result_t r;
    status_t st;
    if (!err) begin
      if (pos_cnt < FRAME_LEN) begin
        rx_frame[pos_cnt] = b;
      end
      if (pos_cnt < HASHED_LEN) begin
        crc_acc = crc16_x25_step(crc_acc, b);
      end
      if (pos_cnt < FRAME_LEN + 1) begin
        pos_cnt = pos_cnt + 1'b1;
      end
      if (!eof) begin
        return;
      end
    end
    if (err || pos_cnt != FRAME_LEN) begin
      st = STATUS_XFER;
    end else begin
      st = judge_frame();
    end
    pos_cnt  = '0;
    crc_acc  = CRC_INIT;
    n_frames = n_frames + 1;
    if (st == STATUS_XFER) begin
      n_gen_fail = n_gen_fail + 1;
    end else if (st != STATUS_OK) begin
      n_hash_fail = n_hash_fail + 1;
    end
    r = '0;
    r.shutdown_request = 1'b0;
    if (!shutdown_done && kept_payload[1][7]) begin
      shutdown_done      = 1'b1;
      r.shutdown_request = 1'b1;
    end
    for (int k = 0; k < 8; k++) begin
      r.good_payload_low[8*k +: 8] = kept_payload[k];
    end
    r.status             = st;
    r.good_payload_high  = kept_payload[8];
    r.read_count         = n_frames;
    r.hash_fail_count    = n_hash_fail;
    r.general_fail_count = n_gen_fail;
    pending_verdicts.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void seal_tx_frame();
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int k = 0; k < HASHED_LEN; k++) begin
      acc = crc16_x25_step(acc, tx_frame[k]);
    end
    acc = ~acc;
    tx_frame[9]  = acc[7:0];
    tx_frame[10] = acc[15:8];
  endfunction

  // 0: byte 0 matches reference, 1: byte 1 bits [6:0] match reference, 2: both differ, 3: free
  function automatic void compose_frame(int mode);
    for (int k = 0; k < 16; k++) begin
      tx_frame[k] = 8'($urandom);
    end
    case (mode)
      0: begin
        tx_frame[0] = anchor_b0;
      end
      1: begin
        tx_frame[1][6:0] = anchor_b1;
      end
      2: begin
        tx_frame[0]      = anchor_b0 ^ 8'($urandom_range(1, 255));
        tx_frame[1][6:0] = anchor_b1 ^ 7'($urandom_range(1, 127));
      end
      default: ;
    endcase
    seal_tx_frame();
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, logic err);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= err;
    do @(posedge clk); while (!s_tready);
    absorb_byte(b, last, err);
    bytes_sent++;
  endtask

  // err_at < 0: clean frame; otherwise that byte carries a transfer error
  task automatic send_frame(int len, int err_at);
    for (int k = 0; k < len; k++) begin
      if (k == err_at) begin
        send_byte(tx_frame[k], 1'($urandom_range(0, 1)), 1'b1);
        return;
      end
      send_byte(tx_frame[k], k == len - 1, 1'b0);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic test_framing_edges();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    for (int k = 0; k < 16; k++) begin
      tx_frame[k] = 8'hFF;
    end
    seal_tx_frame();
    send_frame(FRAME_LEN, -1);
    for (int k = 0; k < 16; k++) begin
      tx_frame[k] = 8'h00;
    end
    send_frame(FRAME_LEN + 1, -1);
  endtask

  task automatic test_random_traffic(int n_bytes);
    int stop_at;
    int r;
    int len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        no_gaps = !no_gaps;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        compose_frame($urandom_range(0, 3));
        send_frame(FRAME_LEN, -1);
      end else if (r < 55) begin
        repeat ($urandom_range(2, 4)) begin
          compose_frame(2);
          send_frame(FRAME_LEN, -1);
        end
      end else if (r < 67) begin
        compose_frame($urandom_range(0, 3));
        tx_frame[$urandom_range(0, 10)] ^= 8'(1 << $urandom_range(0, 7));
        send_frame(FRAME_LEN, -1);
      end else if (r < 77) begin
        compose_frame(3);
        send_frame($urandom_range(1, FRAME_LEN - 1), -1);
      end else if (r < 85) begin
        compose_frame(3);
        send_frame($urandom_range(FRAME_LEN + 1, 15), -1);
      end else if (r < 95) begin
        compose_frame($urandom_range(0, 3));
        len = $urandom_range(1, FRAME_LEN);
        send_frame(len, $urandom_range(0, len - 1));
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (6) begin
      compose_frame($urandom_range(0, 1));
      send_frame(FRAME_LEN, -1);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_for_results();
    repeat (3) begin
      compose_frame($urandom_range(0, 3));
      send_frame(FRAME_LEN, -1);
    end
    wait_results_drained();
    compose_frame(0);
    send_frame(FRAME_LEN, -1);
  endtask

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, seen);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transaction, actual %0h", $time, m_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("good_payload_low", want.good_payload_low, got.good_payload_low);
        compare_field("good_payload_high", 64'(want.good_payload_high),
                      64'(got.good_payload_high));
        compare_field("shutdown_request", 64'(want.shutdown_request),
                      64'(got.shutdown_request));
        compare_field("read_count", 64'(want.read_count), 64'(got.read_count));
        compare_field("hash_fail_count", 64'(want.hash_fail_count),
                      64'(got.hash_fail_count));
        compare_field("general_fail_count", 64'(want.general_fail_count),
                      64'(got.general_fail_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("crc_checked_frame_filter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side ready, with random stalls and one long hold-off on request
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    s_tuser       = 1'b0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    pos_cnt       = '0;
    crc_acc       = CRC_INIT;
    anchor_b0     = '0;
    anchor_b1     = '0;
    reject_streak = '0;
    shutdown_done = 1'b0;
    n_frames      = '0;
    n_hash_fail   = '0;
    n_gen_fail    = '0;
    for (int k = 0; k < FRAME_LEN; k++) begin
      rx_frame[k] = '0;
    end
    for (int k = 0; k < HASHED_LEN; k++) begin
      kept_payload[k] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_framing_edges();
    test_random_traffic(420);
    test_output_backpressure();
    test_pause_for_results();
    test_random_traffic(400);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("crc_checked_frame_filter: match");
    end else begin
      $display("crc_checked_frame_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
